### src/lowest_free_slot_interval_allocator_assert.svh
// assertion macros used by the allocator top level
`ifndef LOWEST_FREE_SLOT_INTERVAL_ALLOCATOR_ASSERT_SVH
`define LOWEST_FREE_SLOT_INTERVAL_ALLOCATOR_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define LFSIA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define LFSIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lfsia_pkg.sv
// types, constants and helpers of the lowest free slot allocator
package lfsia_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int K_W       = $clog2(MAX_SLOTS + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    localparam int TIME_W  = 31;
    localparam int CNT_W   = 20;
    localparam int SLOT_W  = 7;
    localparam int BEST_W  = 21;
    localparam int CFG_W   = 7;
    localparam int TOT_W   = CNT_W + $clog2(MAX_SLOTS + 1);
    localparam int ENTRY_W = TIME_W + CNT_W;

    localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 7'd64;
    localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};

    typedef logic [K_W-1:0]    t_k;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [TOT_W-1:0]  t_tot;
    typedef logic [BEST_W-1:0] t_best;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CFG_W-1:0]  t_cfg;

    typedef struct packed {
        logic              category;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic              last;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_assigned;
        logic              answer_valid;
        logic [BEST_W-1:0] best_total;
    } t_out;

    // one ram word per slot: end time of latest booking and served count
    typedef struct packed {
        logic [TIME_W-1:0] busy;
        logic [CNT_W-1:0]  cnt;
    } t_entry;

    // sequencer controls for the split evaluator
    typedef struct packed {
        logic clr;
        logic acc;
        logic take_a;
        logic take_b;
        logic eval;
    } t_split_ctl;

    function automatic t_cnt sat_add(input t_cnt a, input t_cnt b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

### src/lfsia_ram.sv
// generic single write port ram with registered read
module lfsia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/lfsia_split.sv
// split evaluator: category b total, category a prefix sum and best split
module lfsia_split (
    input  logic                  i_clk,
    input  lfsia_pkg::t_split_ctl i_ctl,
    input  lfsia_pkg::t_cnt       i_cnt,
    output lfsia_pkg::t_best      o_best
);

    lfsia_pkg::t_tot  r_rem;
    lfsia_pkg::t_cnt  r_pre_a;
    lfsia_pkg::t_best r_best;

    lfsia_pkg::t_cnt  rem_c;
    lfsia_pkg::t_best cand;

    // category b prefix of the current split, clamped like the saturating sum
    assign rem_c = (r_rem > lfsia_pkg::t_tot'(lfsia_pkg::CNT_MAX)) ?
                   lfsia_pkg::CNT_MAX : lfsia_pkg::t_cnt'(r_rem);
    assign cand  = lfsia_pkg::t_best'(r_pre_a) + lfsia_pkg::t_best'(rem_c);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_rem   <= '0;
            r_pre_a <= '0;
            r_best  <= '0;
        end else begin
            if (i_ctl.acc) begin
                r_rem <= r_rem + lfsia_pkg::t_tot'(i_cnt);
            end
            if (i_ctl.take_b) begin
                r_rem <= r_rem - lfsia_pkg::t_tot'(i_cnt);
            end
            if (i_ctl.take_a) begin
                r_pre_a <= lfsia_pkg::sat_add(r_pre_a, i_cnt);
            end
            if (i_ctl.eval && (cand > r_best)) begin
                r_best <= cand;
            end
        end
    end

    assign o_best = r_best;

endmodule

### src/lowest_free_slot_interval_allocator.sv
// top level of the lowest free slot interval allocator
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+---------------------------
//  input   | i_in_valid  | o_in_stall   | i_in_data  (t_in)
//  output  | o_out_valid | i_out_stall  | o_out_data (t_out)
//  config  | i_cfg_we    | none         | i_cfg_data (slot_count)
//
// one booking at a time; the scan reads the slot ram one slot per cycle, in slot order, until it
//   finds a free slot or has read all n slots with none free, and then drops the booking
// a last booking then totals the category b counts and walks the splits; the split walk
//   alternates a and b reads through the same ram port
// reset is synchronous active low; used bits clear at once, so no ram clearing pass
// finished beat waits in an output register; a stall holds the next booking in its last step

`include "lowest_free_slot_interval_allocator_assert.svh"

module lowest_free_slot_interval_allocator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lfsia_pkg::t_in      i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lfsia_pkg::t_out     o_out_data,
    input  logic                i_cfg_we,
    input  lfsia_pkg::t_cfg     i_cfg_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;  // look for the lowest free slot
    localparam logic [2:0] S_SUMB = 3'd2;  // total of category b counts
    localparam logic [2:0] S_EVAL = 3'd3;  // score split i, read a[i]
    localparam logic [2:0] S_RDA  = 3'd4;  // take a[i], read b[n-1-i]
    localparam logic [2:0] S_RDB  = 3'd5;  // take b[n-1-i]
    localparam logic [2:0] S_DONE = 3'd6;  // hand the beat to the output register

    logic [2:0] r_state, n_state;

    // configuration
    lfsia_pkg::t_cfg r_slot_count;

    // latched booking
    logic                          r_cat;
    logic [lfsia_pkg::TIME_W-1:0]  r_st;
    logic [lfsia_pkg::TIME_W-1:0]  r_en;
    logic                          r_last;
    lfsia_pkg::t_k                 r_n;

    // scan and walk counters
    lfsia_pkg::t_k    r_k, n_k;
    lfsia_pkg::t_k    r_i, n_i;
    lfsia_pkg::t_k    r_slot, n_slot;
    logic             r_rd_vld, n_rd_vld;
    lfsia_pkg::t_addr r_rd_addr, n_rd_addr;

    // per-slot used bits; a clear entry reads as never booked with count zero
    logic [lfsia_pkg::RAM_DEPTH-1:0] r_used;

    // output register
    logic            r_out_vld;
    lfsia_pkg::t_out r_out;

    // ram side
    logic                         ram_we;
    lfsia_pkg::t_addr             ram_raddr;
    logic [lfsia_pkg::ENTRY_W-1:0] ram_rdata;
    lfsia_pkg::t_entry            ram_wdata;
    lfsia_pkg::t_entry            rd_entry;

    logic                 in_accept;
    logic                 out_load;
    logic                 rd_used;
    logic                 rd_free;
    lfsia_pkg::t_cnt      rd_cnt;
    logic                 issue;
    lfsia_pkg::t_idx      k_idx;
    lfsia_pkg::t_k        b_k;
    logic                 scan_found;
    lfsia_pkg::t_k        n_eff;
    lfsia_pkg::t_split_ctl split_ctl;
    lfsia_pkg::t_best     best;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // slot_count above the bank size acts as the bank size
    assign n_eff = (32'(r_slot_count) > lfsia_pkg::MAX_SLOTS) ?
                   lfsia_pkg::t_k'(lfsia_pkg::MAX_SLOTS) : lfsia_pkg::t_k'(r_slot_count);

    // data of the read issued last cycle
    assign rd_entry = lfsia_pkg::t_entry'(ram_rdata);
    assign rd_used  = r_used[r_rd_addr];
    assign rd_cnt   = rd_used ? rd_entry.cnt : '0;
    assign rd_free  = !rd_used || (rd_entry.busy < r_st);

    assign issue      = (r_k < r_n);
    assign k_idx      = r_k[lfsia_pkg::IDX_W-1:0];
    assign b_k        = r_n - r_i - lfsia_pkg::t_k'(1);
    assign scan_found = (r_state == S_SCAN) && r_rd_vld && rd_free;

    // booking write-back: new end time, bumped count
    assign ram_wdata.busy = r_en;
    assign ram_wdata.cnt  = lfsia_pkg::sat_add(rd_cnt, lfsia_pkg::t_cnt'(1));

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_i       = r_i;
        n_slot    = r_slot;
        n_rd_vld  = 1'b0;
        n_rd_addr = r_rd_addr;
        ram_raddr = r_rd_addr;
        ram_we    = 1'b0;
        split_ctl = '0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_k     = '0;
                    n_slot  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_found) begin
                    ram_we        = 1'b1;
                    n_slot        = lfsia_pkg::t_k'(r_rd_addr[lfsia_pkg::IDX_W-1:0]) +
                                    lfsia_pkg::t_k'(1);
                    n_k           = '0;
                    split_ctl.clr = r_last;
                    n_state       = r_last ? S_SUMB : S_DONE;
                end else if (issue) begin
                    ram_raddr = {r_cat, k_idx};
                    n_rd_addr = {r_cat, k_idx};
                    n_rd_vld  = 1'b1;
                    n_k       = r_k + lfsia_pkg::t_k'(1);
                end else if (!r_rd_vld) begin
                    // every slot busy: dropped
                    n_k           = '0;
                    split_ctl.clr = r_last;
                    n_state       = r_last ? S_SUMB : S_DONE;
                end
            end
            S_SUMB: begin
                split_ctl.acc = r_rd_vld;
                if (issue) begin
                    ram_raddr = {1'b1, k_idx};
                    n_rd_addr = {1'b1, k_idx};
                    n_rd_vld  = 1'b1;
                    n_k       = r_k + lfsia_pkg::t_k'(1);
                end else if (!r_rd_vld) begin
                    n_i     = '0;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                split_ctl.eval = 1'b1;
                if (r_i == r_n) begin
                    n_state = S_DONE;
                end else begin
                    ram_raddr = {1'b0, r_i[lfsia_pkg::IDX_W-1:0]};
                    n_rd_addr = {1'b0, r_i[lfsia_pkg::IDX_W-1:0]};
                    n_state   = S_RDA;
                end
            end
            S_RDA: begin
                split_ctl.take_a = 1'b1;
                ram_raddr        = {1'b1, b_k[lfsia_pkg::IDX_W-1:0]};
                n_rd_addr        = {1'b1, b_k[lfsia_pkg::IDX_W-1:0]};
                n_state          = S_RDB;
            end
            S_RDB: begin
                split_ctl.take_b = 1'b1;
                n_i              = r_i + lfsia_pkg::t_k'(1);
                n_state          = S_EVAL;
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_used       <= '0;
            r_slot_count <= lfsia_pkg::SLOT_COUNT_RST;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            if (i_cfg_we) begin
                r_slot_count <= i_cfg_data;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            // the data set ends with the last beat: forget every slot
            if (out_load && r_last) begin
                r_used <= '0;
            end else if (scan_found) begin
                r_used[r_rd_addr] <= 1'b1;
            end
        end
    end

    // payload and counters
    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_i       <= n_i;
        r_slot    <= n_slot;
        r_rd_addr <= n_rd_addr;
        if (in_accept) begin
            r_cat  <= i_in_data.category;
            r_st   <= i_in_data.start_time;
            r_en   <= i_in_data.end_time;
            r_last <= i_in_data.last;
            r_n    <= n_eff;
        end
        if (out_load) begin
            r_out.slot_assigned <= lfsia_pkg::t_slot'(r_slot);
            r_out.answer_valid  <= r_last;
            r_out.best_total    <= r_last ? best : '0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    lfsia_ram #(
        .WIDTH (lfsia_pkg::ENTRY_W),
        .DEPTH (lfsia_pkg::RAM_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rd_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lfsia_split u_split (
        .i_clk  (i_clk),
        .i_ctl  (split_ctl),
        .i_cnt  (rd_cnt),
        .o_best (best)
    );

    `LFSIA_ASSERT_NEXT(a_accept_starts_scan, in_accept, r_state == S_SCAN, "beat did not start a scan")
    `LFSIA_ASSERT_NOW(a_found_within_count, scan_found, r_rd_addr[lfsia_pkg::IDX_W-1:0] < r_n, "slot beyond count")
    `LFSIA_ASSERT_NOW(a_slot_within_count, out_load, r_slot <= r_n, "assigned slot beyond count")
    `LFSIA_ASSERT_NEXT(a_clear_after_last, out_load && r_last, r_used == '0, "slots not cleared after last")

endmodule

### bench/tb_lowest_free_slot_interval_allocator.sv
// self-checking testbench for the lowest free slot interval allocator
`timescale 1ns / 1ps

module tb_lowest_free_slot_interval_allocator;
    import lfsia_pkg::*;

    // cycles with no beat on either channel before the run is declared hung;
    // the slowest beat is a last booking at 64 slots, and the long receiver
    // hold-off is set by LONG_HOLD
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned TAIL_CYCLES    = 400;
    localparam int unsigned RANDOM_ITEMS   = 2000;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    // shapes of a random booking set
    typedef enum int unsigned {
        SET_SPARSE,     // well-formed, little overlap, low slots
        SET_CROWDED,    // well-formed, long bookings pile up into high slots and drops
        SET_NOISE,      // random times and categories, no ordering at all
        SET_BACKWARD    // start times descending within each category
    } t_set_style;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    logic  o_in_stall;
    t_in   i_in_data   = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_out  o_out_data;
    logic  i_cfg_we    = 1'b0;
    t_cfg  i_cfg_data  = '0;

    // shadow of the allocator: configuration, slot banks and results still owed
    t_cfg              slot_limit = SLOT_COUNT_RST;
    bit                slot_taken      [2*MAX_SLOTS];
    bit [TIME_W-1:0]   slot_free_after [2*MAX_SLOTS];
    bit [CNT_W-1:0]    slot_served     [2*MAX_SLOTS];
    t_out              grants_due [$];

    bit          idling_on      = 1'b1;
    int unsigned hold_left      = 0;
    int unsigned stall_left     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned mismatch_count = 0;
    int unsigned bookings_sent  = 0;

    lowest_free_slot_interval_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_ledger();
        foreach (slot_taken[k]) begin
            slot_taken[k]      = 1'b0;
            slot_free_after[k] = '0;
            slot_served[k]     = '0;
        end
    endfunction

    // first fit in the booking's bank, then on a last booking the best split
    // of the first n slots between the two banks
    function automatic t_out book_and_score(input t_in b);
        int unsigned n, base, k, best;
        int unsigned sum_a [MAX_SLOTS+1];
        int unsigned sum_b [MAX_SLOTS+1];
        bit   found;
        t_out r;
        r     = '0;
        found = 1'b0;
        best  = 0;
        // anything above the bank size behaves as the full bank
        n    = (slot_limit > MAX_SLOTS) ? MAX_SLOTS : slot_limit;
        base = b.category ? MAX_SLOTS : 0;
        for (k = 0; k < n; k++) begin
            // free means never used, or its booking ended strictly before this start
            if (!found && (!slot_taken[base+k] || slot_free_after[base+k] < b.start_time)) begin
                found                  = 1'b1;
                slot_taken[base+k]     = 1'b1;
                slot_free_after[base+k] = b.end_time;
                if (slot_served[base+k] != CNT_MAX)
                    slot_served[base+k] = slot_served[base+k] + 1'b1;
                r.slot_assigned = SLOT_W'(k + 1);
            end
        end
        if (b.last) begin
            // running totals per bank, each capped like the per-slot counts;
            // slots past n are left out even if they hold counts
            sum_a[0] = 0;
            sum_b[0] = 0;
            for (k = 0; k < n; k++) begin
                sum_a[k+1] = sum_a[k] + slot_served[k];
                sum_b[k+1] = sum_b[k] + slot_served[MAX_SLOTS+k];
                if (sum_a[k+1] > CNT_MAX) sum_a[k+1] = CNT_MAX;
                if (sum_b[k+1] > CNT_MAX) sum_b[k+1] = CNT_MAX;
            end
            for (k = 0; k <= n; k++) begin
                if (sum_a[k] + sum_b[n-k] > best) best = sum_a[k] + sum_b[n-k];
            end
            r.answer_valid = 1'b1;
            r.best_total   = BEST_W'(best);
            clear_ledger();
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- driving

    function automatic t_in booking_of(input bit cat, input logic [TIME_W-1:0] s,
                                       input logic [TIME_W-1:0] e, input bit fin);
        t_in b;
        b.category   = cat;
        b.start_time = s;
        b.end_time   = e;
        b.last       = fin;
        return b;
    endfunction

    // offers one beat after a random gap and returns at the edge that takes it;
    // valid stays high so a following call with no gap keeps the channel busy
    task automatic send_booking(input t_in b);
        int unsigned gap;
        t_out        owed;
        gap = idling_on ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = b;
        do @(posedge i_clk); while (o_in_stall);
        owed       = book_and_score(b);
        grants_due = {grants_due, owed};
        bookings_sent++;
    endtask

    // drops valid, waits for every owed beat, then lets the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (grants_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_slot_count(input t_cfg v);
        wait_idle();
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        slot_limit = v;
    endtask

    function automatic t_cfg draw_slot_count();
        case ($urandom_range(0, 7))
            0:       return t_cfg'(0);
            1:       return t_cfg'(1);
            2:       return t_cfg'(MAX_SLOTS);
            3:       return '1;
            4:       return t_cfg'($urandom_range(MAX_SLOTS + 1, 127));
            5, 6:    return t_cfg'($urandom_range(2, 8));
            default: return t_cfg'($urandom_range(0, 127));
        endcase
    endfunction

    // ---------------------------------------------------------------- receiving

    // receiver stall: a long hold-off when asked, else the wait drawn per beat
    always @(negedge i_clk) begin : result_pacer
        if (hold_left != 0) begin
            hold_left   = hold_left - 1;
            i_out_stall = 1'b1;
        end else if (stall_left != 0) begin
            stall_left  = stall_left - 1;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin : grant_checker
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            stall_left = idling_on ? $urandom_range(0, 5) : 0;
            if (grants_due.size() == 0) begin
                $error("beat with nothing owed: slot_assigned %0d answer_valid %0d best_total %0d",
                       o_out_data.slot_assigned, o_out_data.answer_valid,
                       o_out_data.best_total);
                mismatch_count++;
            end else begin
                want = grants_due.pop_front();
                if (o_out_data.slot_assigned !== want.slot_assigned) begin
                    $error("slot_assigned: expected %0d, got %0d",
                           want.slot_assigned, o_out_data.slot_assigned);
                    mismatch_count++;
                end
                if (o_out_data.answer_valid !== want.answer_valid) begin
                    $error("answer_valid: expected %0d, got %0d",
                           want.answer_valid, o_out_data.answer_valid);
                    mismatch_count++;
                end
                if (o_out_data.best_total !== want.best_total) begin
                    $error("best_total: expected %0d, got %0d",
                           want.best_total, o_out_data.best_total);
                    mismatch_count++;
                end
            end
        end
    end

    // hang detector: any beat on either channel restarts the count
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("no beat for %0d cycles, %0d results still owed",
                       quiet_cycles, grants_due.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // reset value of 64 slots; a slot whose booking ends at the new start is
    // still busy, one that ended a tick earlier is free again
    task automatic test_first_fit();
        send_booking(booking_of(1'b0, 10, 20, 1'b0));
        send_booking(booking_of(1'b0, 11, 30, 1'b0));
        send_booking(booking_of(1'b0, 20, 25, 1'b0));
        send_booking(booking_of(1'b0, 21, 22, 1'b0));
        send_booking(booking_of(1'b1, 5, 100, 1'b0));
        send_booking(booking_of(1'b1, 6, 7, 1'b0));
        send_booking(booking_of(1'b1, 101, 200, 1'b1));
    endtask

    // time fields at both ends, and end times before their start
    task automatic test_time_extremes();
        send_booking(booking_of(1'b0, 0, TIME_TOP, 1'b0));
        send_booking(booking_of(1'b0, TIME_TOP, TIME_TOP, 1'b0));
        send_booking(booking_of(1'b1, TIME_TOP - TIME_W'(1), 0, 1'b0));
        send_booking(booking_of(1'b1, TIME_TOP, 0, 1'b1));
    endtask

    // no slots at all: everything dropped and the answer is zero
    task automatic test_zero_slots();
        set_slot_count('0);
        send_booking(booking_of(1'b0, 1, 2, 1'b0));
        send_booking(booking_of(1'b1, 1, 2, 1'b0));
        send_booking(booking_of(1'b0, 3, 4, 1'b1));
    endtask

    // a single slot drops overlaps; the largest register value acts as 64
    task automatic test_slot_count_bounds();
        set_slot_count(t_cfg'(1));
        send_booking(booking_of(1'b0, 1, 5, 1'b0));
        send_booking(booking_of(1'b0, 2, 3, 1'b0));
        send_booking(booking_of(1'b1, 4, 9, 1'b0));
        send_booking(booking_of(1'b0, 6, 7, 1'b1));
        set_slot_count('1);
        send_booking(booking_of(1'b1, 10, 20, 1'b0));
        send_booking(booking_of(1'b1, 11, 12, 1'b0));
        send_booking(booking_of(1'b0, 5, 9, 1'b1));
    endtask

    // shrinking the slot count inside a set: later bookings and the final sums
    // see only the first two slots, the count left in slot 3 is ignored
    task automatic test_midset_slot_change();
        set_slot_count(t_cfg'(MAX_SLOTS));
        send_booking(booking_of(1'b0, 1, 100, 1'b0));
        send_booking(booking_of(1'b0, 2, 100, 1'b0));
        send_booking(booking_of(1'b0, 3, 100, 1'b0));
        send_booking(booking_of(1'b1, 1, 100, 1'b0));
        set_slot_count(t_cfg'(2));
        send_booking(booking_of(1'b0, 4, 5, 1'b0));
        send_booking(booking_of(1'b1, 2, 3, 1'b1));
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    // beats back to back, so the block fills and stalls its input
    task automatic test_output_backpressure();
        int unsigned k;
        set_slot_count(t_cfg'(MAX_SLOTS));
        idling_on = 1'b0;
        @(posedge i_clk);
        hold_left = LONG_HOLD;
        for (k = 0; k < 12; k++)
            send_booking(booking_of(k[0], TIME_W'(100 * k), TIME_W'(100 * k + 150), k == 11));
        wait_idle();
        idling_on = 1'b1;
    endtask

    // one data set of random bookings ending in a last beat
    task automatic run_booking_set(input int unsigned len, input t_set_style style,
                                   input bit change_midway);
        logic [TIME_W-1:0] cursor [2];
        logic [TIME_W-1:0] s, e;
        int unsigned k, step, dur;
        bit major, cat;
        major = ($urandom_range(0, 1) != 0);
        if (style == SET_BACKWARD) begin
            cursor[0] = TIME_W'($urandom_range(32'h0010_0000, 32'h7FFF_FFFF));
            cursor[1] = TIME_W'($urandom_range(32'h0010_0000, 32'h7FFF_FFFF));
        end else begin
            cursor[0] = TIME_W'($urandom_range(0, 32'h7FF0_0000));
            cursor[1] = TIME_W'($urandom_range(0, 32'h7FF0_0000));
        end
        for (k = 0; k < len; k++) begin
            // crowded sets lean on one bank so it runs out of slots
            if (style == SET_CROWDED)
                cat = major ^ ($urandom_range(0, 7) == 0);
            else
                cat = ($urandom_range(0, 1) != 0);
            case (style)
                SET_CROWDED: begin
                    step = $urandom_range(1, 3);
                    dur  = $urandom_range(200, 1_000_000);
                end
                SET_BACKWARD: begin
                    step = $urandom_range(1, 40);
                    dur  = $urandom_range(0, 80);
                end
                default: begin
                    step = $urandom_range(1, 60);
                    dur  = $urandom_range(0, 120);
                end
            endcase
            if (style == SET_NOISE) begin
                s = TIME_W'($urandom);
                e = TIME_W'($urandom);
            end else begin
                if (style == SET_BACKWARD)
                    cursor[cat] = cursor[cat] - TIME_W'(step);
                else
                    cursor[cat] = cursor[cat] + TIME_W'(step);
                s = cursor[cat];
                e = (TIME_TOP - s < dur) ? TIME_TOP : s + TIME_W'(dur);
            end
            if (change_midway && k == len / 2)
                set_slot_count(draw_slot_count());
            send_booking(booking_of(cat, s, e, k == len - 1));
        end
    endtask

    task automatic test_random_sets();
        int unsigned target, pick;
        t_set_style  style;
        target = bookings_sent + RANDOM_ITEMS;
        while (bookings_sent < target) begin
            // some sets run with no idling on either side
            idling_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1))
                set_slot_count(draw_slot_count());
            pick = $urandom_range(0, 9);
            if (pick <= 3)      style = SET_SPARSE;
            else if (pick <= 6) style = SET_CROWDED;
            else if (pick == 7) style = SET_NOISE;
            else                style = SET_BACKWARD;
            run_booking_set((style == SET_CROWDED) ? $urandom_range(1, 90)
                                                   : $urandom_range(1, 40),
                            style, $urandom_range(0, 9) == 0);
        end
        idling_on = 1'b1;
    endtask

    initial begin
        clear_ledger();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_first_fit();
        test_time_extremes();
        test_zero_slots();
        test_slot_count_bounds();
        test_midset_slot_change();
        test_output_backpressure();
        test_random_sets();

        // everything owed has arrived; watch a while longer for stray beats
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### lowest_free_slot_interval_allocator.f
+incdir+src
src/lfsia_pkg.sv
src/lfsia_ram.sv
src/lfsia_split.sv
src/lowest_free_slot_interval_allocator.sv
bench/tb_lowest_free_slot_interval_allocator.sv
